[src/ski_pkg.sv]
// Shared types, widths and constants of the servo keyframe interpolator.
// Used by the divider, the datapath, the controller and the top level.
// No dependencies.
package ski_pkg;

    localparam int NUM_SERVOS  = 3;
    localparam int NUM_TARGETS = 3;
    localparam int IDX_W       = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

    localparam int ANGLE_W  = 8;
    localparam int INC_W    = 9;
    localparam int STEP_W   = 9;
    localparam int COUNT_W  = 8;
    localparam int VEL_W    = 8;
    localparam int PERIOD_W = 16;
    localparam int LIMIT_W  = 8;
    localparam int DUR_W    = 16;
    localparam int MASK_W   = 3;
    localparam int SUM_W    = ANGLE_W + 2;
    localparam int SEC_W    = 9;
    localparam int MS_W     = 10;
    localparam int PROD_W   = SEC_W + MS_W;

    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int IN_W   = 48;
    localparam int OUT_W  = 40;
    localparam int USER_W = 2;

    localparam int MASK_LSB  = 0;
    localparam int LEFT_LSB  = MASK_LSB + MASK_W;
    localparam int RIGHT_LSB = LEFT_LSB + ANGLE_W;
    localparam int HEAD_LSB  = RIGHT_LSB + ANGLE_W;
    localparam int DUR_LSB   = HEAD_LSB + ANGLE_W;

    localparam int USER_HIB   = 0;
    localparam int USER_TAKEN = 1;

    localparam logic [ANGLE_W-1:0]  MAX_ANGLE    = 8'd180;
    localparam logic [ANGLE_W-1:0]  HOME_ANGLE   = 8'd90;
    localparam logic [MS_W-1:0]     MS_PER_S     = 10'd1000;
    localparam logic [VEL_W-1:0]    VEL_RESET    = 8'd60;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

    localparam logic [1:0] DIV_SEC = 2'd0;
    localparam logic [1:0] DIV_CNT = 2'd1;
    localparam logic [1:0] DIV_INC = 2'd2;

    typedef struct packed {
        logic             capture;
        logic             set_hib;
        logic             tick_step;
        logic             take;
        logic             div_start;
        logic [1:0]       div_sel;
        logic             store_sec;
        logic             store_cnt;
        logic             store_inc;
        logic             move;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } ski_cmd_t;

    typedef struct packed {
        logic hib;
        logic plan_needed;
        logic div_busy;
        logic count_zero;
        logic out_free;
    } ski_stat_t;

    function automatic logic [ANGLE_W-1:0] sat_angle(input logic [ANGLE_W-1:0] a);
        return (a > MAX_ANGLE) ? MAX_ANGLE : a;
    endfunction

endpackage

[src/ski_divider.sv]
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Depends on ski_pkg for its width.
module ski_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ski_pkg::DIV_W-1:0] dividend,
    input  logic [ski_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic [ski_pkg::DIV_W-1:0] quotient
);

    logic [ski_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [ski_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [ski_pkg::DIV_W-1:0]     dvs_reg, dvs_next;
    logic [ski_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ski_pkg::DIV_W:0]       shifted;
    logic [ski_pkg::DIV_W:0]       trial;

    assign shifted = {rem_reg, quo_reg[ski_pkg::DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = ski_pkg::DIV_CNT_W'(ski_pkg::DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[ski_pkg::DIV_W])
            begin
                rem_next = trial[ski_pkg::DIV_W-1:0];
                quo_next = {quo_reg[ski_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[ski_pkg::DIV_W-1:0];
                quo_next = {quo_reg[ski_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

[src/ski_datapath.sv]
// Datapath: configuration, servo state, planning arithmetic and the result register.
// Depends on ski_pkg and instantiates ski_divider.
module ski_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ski_pkg::ski_cmd_t             cmd,
    output ski_pkg::ski_stat_t            stat,
    input  logic [ski_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ski_pkg::OUT_W-1:0]     m_tdata,
    output logic [ski_pkg::USER_W-1:0]    m_tuser,
    input  logic                          cfg_we,
    input  logic [ski_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ski_pkg::CFG_W-1:0]     cfg_data
);

    localparam int N = ski_pkg::NUM_SERVOS;

    logic [ski_pkg::VEL_W-1:0]    vel_reg, vel_next;
    logic [ski_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [ski_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic [ski_pkg::LIMIT_W-1:0]  tick_reg, tick_next;

    logic [ski_pkg::ANGLE_W-1:0]  cur_reg [N];
    logic [ski_pkg::ANGLE_W-1:0]  cur_next [N];
    logic [ski_pkg::ANGLE_W-1:0]  goal_reg [N];
    logic [ski_pkg::ANGLE_W-1:0]  goal_next [N];
    logic [ski_pkg::INC_W-1:0]    inc_reg [N];
    logic [ski_pkg::INC_W-1:0]    inc_next [N];
    logic [ski_pkg::ANGLE_W-1:0]  given_goal [N];
    logic [ski_pkg::ANGLE_W-1:0]  moved [N];

    logic [ski_pkg::STEP_W-1:0]   steps_reg, steps_next;
    logic [ski_pkg::DUR_W-1:0]    held_reg, held_next;
    logic [ski_pkg::DIV_W-1:0]    longest_reg, longest_next;
    logic [ski_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                         hib_reg, hib_next;
    logic                         taken_reg, taken_next;
    logic [ski_pkg::DUR_W-1:0]    sleep_reg, sleep_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    logic [ski_pkg::MASK_W-1:0]   mask_reg;
    logic [ski_pkg::ANGLE_W-1:0]  tgt_reg [ski_pkg::NUM_TARGETS];
    logic [ski_pkg::DUR_W-1:0]    dur_reg;

    logic [ski_pkg::ANGLE_W-1:0]  out_angle_reg [ski_pkg::NUM_TARGETS];
    logic [ski_pkg::ANGLE_W-1:0]  out_angle [ski_pkg::NUM_TARGETS];
    logic [ski_pkg::DUR_W-1:0]    out_sleep_reg;
    logic                         out_hib_reg;
    logic                         out_taken_reg;

    logic [ski_pkg::VEL_W-1:0]    vel_eff;
    logic [ski_pkg::PERIOD_W-1:0] period_eff;
    logic [ski_pkg::ANGLE_W-1:0]  sel_goal;
    logic [ski_pkg::ANGLE_W-1:0]  sel_cur;
    logic                         sel_neg;
    logic [ski_pkg::ANGLE_W-1:0]  sel_diff;
    logic [ski_pkg::DIV_W-1:0]    div_dividend;
    logic [ski_pkg::DIV_W-1:0]    div_divisor;
    logic                         div_busy;
    logic [ski_pkg::DIV_W-1:0]    div_quo;
    logic [ski_pkg::SEC_W-1:0]    quo_small;
    logic [ski_pkg::PROD_W-1:0]   sec_ms;
    logic [ski_pkg::DIV_W-1:0]    move_ms;
    logic                         last_step;

    ski_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign vel_eff    = (vel_reg == '0) ? ski_pkg::VEL_W'(1) : vel_reg;
    assign period_eff = (period_reg == '0) ? ski_pkg::PERIOD_W'(1) : period_reg;

    assign sel_goal = goal_reg[cmd.idx];
    assign sel_cur  = cur_reg[cmd.idx];
    assign sel_neg  = (sel_goal < sel_cur);
    assign sel_diff = sel_neg ? (sel_cur - sel_goal) : (sel_goal - sel_cur);

    always_comb
    begin
        unique case (cmd.div_sel)
            ski_pkg::DIV_SEC:
            begin
                div_dividend = ski_pkg::DIV_W'(sel_diff) + ski_pkg::DIV_W'(vel_eff)
                               - ski_pkg::DIV_W'(1);
                div_divisor  = ski_pkg::DIV_W'(vel_eff);
            end
            ski_pkg::DIV_CNT:
            begin
                div_dividend = longest_reg;
                div_divisor  = period_eff;
            end
            ski_pkg::DIV_INC:
            begin
                div_dividend = ski_pkg::DIV_W'(sel_diff)
                               + (sel_neg ? (ski_pkg::DIV_W'(count_reg) - ski_pkg::DIV_W'(1))
                                          : ski_pkg::DIV_W'(0));
                div_divisor  = ski_pkg::DIV_W'(count_reg);
            end
            default:
            begin
                div_dividend = longest_reg;
                div_divisor  = period_eff;
            end
        endcase
    end

    assign quo_small = div_quo[ski_pkg::SEC_W-1:0];
    assign sec_ms    = ski_pkg::PROD_W'(quo_small) * ski_pkg::PROD_W'(ski_pkg::MS_PER_S);
    assign move_ms   = sec_ms[ski_pkg::DIV_W-1:0];
    assign last_step = (steps_reg == ski_pkg::STEP_W'(1));

    for (genvar i = 0; i < N; i++)
    begin : g_servo
        logic signed [ski_pkg::SUM_W-1:0] sum;

        if (i < ski_pkg::NUM_TARGETS)
        begin : g_given
            assign given_goal[i] = mask_reg[i] ? ski_pkg::sat_angle(tgt_reg[i]) : cur_reg[i];
        end
        else
        begin : g_fixed
            assign given_goal[i] = cur_reg[i];
        end

        assign sum = $signed({2'b00, cur_reg[i]})
                     + $signed({inc_reg[i][ski_pkg::INC_W-1], inc_reg[i]});

        always_comb
        begin
            if (sum < 0)
            begin
                moved[i] = '0;
            end
            else if (sum > $signed(ski_pkg::SUM_W'(ski_pkg::MAX_ANGLE)))
            begin
                moved[i] = ski_pkg::MAX_ANGLE;
            end
            else
            begin
                moved[i] = sum[ski_pkg::ANGLE_W-1:0];
            end
        end
    end

    for (genvar k = 0; k < ski_pkg::NUM_TARGETS; k++)
    begin : g_out
        if (k < N)
        begin : g_present
            assign out_angle[k] = cur_reg[k];
        end
        else
        begin : g_absent
            assign out_angle[k] = '0;
        end
    end

    always_comb
    begin
        vel_next      = vel_reg;
        period_next   = period_reg;
        limit_next    = limit_reg;
        tick_next     = tick_reg;
        cur_next      = cur_reg;
        goal_next     = goal_reg;
        inc_next      = inc_reg;
        steps_next    = steps_reg;
        held_next     = held_reg;
        longest_next  = longest_reg;
        count_next    = count_reg;
        hib_next      = hib_reg;
        taken_next    = taken_reg;
        sleep_next    = sleep_reg;
        m_tvalid_next = m_tvalid_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                ski_pkg::CFG_VELOCITY:
                begin
                    vel_next = cfg_data[ski_pkg::VEL_W-1:0];
                end
                ski_pkg::CFG_PERIOD:
                begin
                    period_next = cfg_data[ski_pkg::PERIOD_W-1:0];
                end
                ski_pkg::CFG_LIMIT:
                begin
                    limit_next = cfg_data[ski_pkg::LIMIT_W-1:0];
                    tick_next  = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.capture)
        begin
            hib_next   = 1'b0;
            taken_next = 1'b0;
            sleep_next = '0;
        end

        if (cmd.set_hib)
        begin
            hib_next = 1'b1;
        end

        if (cmd.tick_step && (limit_reg != '0))
        begin
            tick_next = tick_reg + 1'b1;
        end

        if (cmd.take)
        begin
            goal_next    = given_goal;
            held_next    = dur_reg;
            longest_next = '0;
            taken_next   = 1'b1;
        end

        if (cmd.store_sec && (move_ms > longest_reg))
        begin
            longest_next = move_ms;
        end

        if (cmd.store_cnt)
        begin
            count_next = div_quo[ski_pkg::COUNT_W-1:0];
            steps_next = ski_pkg::STEP_W'(div_quo[ski_pkg::COUNT_W-1:0]) + 1'b1;
        end

        if (cmd.store_inc)
        begin
            inc_next[cmd.idx] = sel_neg ? (ski_pkg::INC_W'(0) - quo_small) : quo_small;
        end

        if (cmd.move)
        begin
            for (int i = 0; i < N; i++)
            begin
                cur_next[i] = last_step ? goal_reg[i] : moved[i];
            end
            steps_next = steps_reg - 1'b1;
            sleep_next = last_step ? held_reg : '0;
        end

        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg      <= ski_pkg::VEL_RESET;
            period_reg   <= ski_pkg::PERIOD_RESET;
            limit_reg    <= ski_pkg::LIMIT_RESET;
            tick_reg     <= '0;
            for (int i = 0; i < N; i++)
            begin
                cur_reg[i]  <= ski_pkg::HOME_ANGLE;
                goal_reg[i] <= ski_pkg::HOME_ANGLE;
                inc_reg[i]  <= '0;
            end
            steps_reg    <= '0;
            held_reg     <= '0;
            longest_reg  <= '0;
            count_reg    <= '0;
            hib_reg      <= 1'b0;
            taken_reg    <= 1'b0;
            sleep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            vel_reg      <= vel_next;
            period_reg   <= period_next;
            limit_reg    <= limit_next;
            tick_reg     <= tick_next;
            cur_reg      <= cur_next;
            goal_reg     <= goal_next;
            inc_reg      <= inc_next;
            steps_reg    <= steps_next;
            held_reg     <= held_next;
            longest_reg  <= longest_next;
            count_reg    <= count_next;
            hib_reg      <= hib_next;
            taken_reg    <= taken_next;
            sleep_reg    <= sleep_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mask_reg   <= s_tdata[ski_pkg::MASK_LSB +: ski_pkg::MASK_W];
            tgt_reg[0] <= s_tdata[ski_pkg::LEFT_LSB +: ski_pkg::ANGLE_W];
            tgt_reg[1] <= s_tdata[ski_pkg::RIGHT_LSB +: ski_pkg::ANGLE_W];
            tgt_reg[2] <= s_tdata[ski_pkg::HEAD_LSB +: ski_pkg::ANGLE_W];
            dur_reg    <= s_tdata[ski_pkg::DUR_LSB +: ski_pkg::DUR_W];
        end
        if (cmd.out_load)
        begin
            out_angle_reg <= out_angle;
            out_sleep_reg <= sleep_reg;
            out_hib_reg   <= hib_reg;
            out_taken_reg <= taken_reg;
        end
    end

    assign stat.hib         = (limit_reg != '0) && (tick_reg == limit_reg);
    assign stat.plan_needed = (steps_reg == '0);
    assign stat.div_busy    = div_busy;
    assign stat.count_zero  = (count_reg == '0);
    assign stat.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_sleep_reg, out_angle_reg[2], out_angle_reg[1], out_angle_reg[0]};
    assign m_tuser  = {out_taken_reg, out_hib_reg};

endmodule

[src/ski_controller.sv]
// Controller state machine that sequences one tick through the datapath.
// Depends on ski_pkg for the command and status structs.
module ski_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ski_pkg::ski_stat_t stat,
    output ski_pkg::ski_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_SEC_GO    = 4'd2;
    localparam logic [3:0] S_SEC_WAIT  = 4'd3;
    localparam logic [3:0] S_CNT_GO    = 4'd4;
    localparam logic [3:0] S_CNT_WAIT  = 4'd5;
    localparam logic [3:0] S_CNT_CHECK = 4'd6;
    localparam logic [3:0] S_INC_GO    = 4'd7;
    localparam logic [3:0] S_INC_WAIT  = 4'd8;
    localparam logic [3:0] S_MOVE      = 4'd9;
    localparam logic [3:0] S_EMIT      = 4'd10;

    localparam logic [ski_pkg::IDX_W-1:0] LAST_IDX = ski_pkg::IDX_W'(ski_pkg::NUM_SERVOS - 1);

    logic [3:0]                state_reg, state_next;
    logic [ski_pkg::IDX_W-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        s_tready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.hib)
                begin
                    cmd.set_hib = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.tick_step = 1'b1;
                    if (stat.plan_needed)
                    begin
                        cmd.take   = 1'b1;
                        idx_next   = '0;
                        state_next = S_SEC_GO;
                    end
                    else
                    begin
                        state_next = S_MOVE;
                    end
                end
            end
            S_SEC_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ski_pkg::DIV_SEC;
                state_next    = S_SEC_WAIT;
            end
            S_SEC_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.store_sec = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_CNT_GO;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SEC_GO;
                    end
                end
            end
            S_CNT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ski_pkg::DIV_CNT;
                state_next    = S_CNT_WAIT;
            end
            S_CNT_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.store_cnt = 1'b1;
                    state_next    = S_CNT_CHECK;
                end
            end
            S_CNT_CHECK:
            begin
                if (stat.count_zero)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_INC_GO;
                end
            end
            S_INC_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ski_pkg::DIV_INC;
                state_next    = S_INC_WAIT;
            end
            S_INC_WAIT:
            begin
                cmd.div_sel = ski_pkg::DIV_INC;
                if (!stat.div_busy)
                begin
                    cmd.store_inc = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_INC_GO;
                    end
                end
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[src/servo_keyframe_interpolator.sv]
// Top level of the servo keyframe interpolator.
// Depends on ski_pkg and instantiates ski_controller and ski_datapath.
//
// Each request on the input stream is one tick and produces exactly one result. A tick
// that continues a keyframe already in progress passes through the check, move and
// emit states to the result register. A tick that takes a new keyframe plans the move
// with one shared 16-bit divider that yields one quotient bit per cycle: three
// move-time divisions, one sub-step count division and, when the count is not zero,
// three increment divisions. One tick is in work at a time; the next request is
// accepted while the previous result still waits on the output.
module servo_keyframe_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // given_mask[2:0], target_left[10:3], target_right[18:11], target_head[26:19],
    // frame_duration_ms[42:27], zero fill above.
    input  logic [ski_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // angle_left[7:0], angle_right[15:8], angle_head[23:16], sleep_ms[39:24].
    output logic [ski_pkg::OUT_W-1:0]     m_tdata,
    // hibernated[0], frame_taken[1].
    output logic [ski_pkg::USER_W-1:0]    m_tuser,
    input  logic                          cfg_we,
    input  logic [ski_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ski_pkg::CFG_W-1:0]     cfg_data
);

    ski_pkg::ski_cmd_t  cmd;
    ski_pkg::ski_stat_t stat;

    ski_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ski_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
